// ----- hw/rtl/fhc_pkg.sv -----
// ----------------------------------------------------------------------------
// fhc_pkg
// types and constants shared by the frame header classifier
// ----------------------------------------------------------------------------
package fhc_pkg;

   // position counter width and the width used for offset arithmetic
   localparam int POSITION_BITS_DEFAULT = 16;
   localparam int EXT_BITS              = 17;
   localparam int LINK_BITS             = 7;
   localparam logic [LINK_BITS-1:0] LINK_HEADER_RESET = 7'd14;

   // ethertypes
   localparam logic [15:0] ETHERTYPE_ARP  = 16'h0806;
   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [15:0] ETHERTYPE_IPV6 = 16'h86DD;

   // ip protocol numbers
   localparam logic [7:0] PROTO_ICMPV4 = 8'd1;
   localparam logic [7:0] PROTO_TCP    = 8'd6;
   localparam logic [7:0] PROTO_UDP    = 8'd17;
   localparam logic [7:0] PROTO_ICMPV6 = 8'd58;

   // well known ports
   localparam logic [15:0] PORT_FTP         = 16'd21;
   localparam logic [15:0] PORT_SSH         = 16'd22;
   localparam logic [15:0] PORT_TELNET      = 16'd23;
   localparam logic [15:0] PORT_HTTP        = 16'd80;
   localparam logic [15:0] PORT_HTTPS       = 16'd443;
   localparam logic [15:0] PORT_DNS         = 16'd53;
   localparam logic [15:0] PORT_DHCP_SERVER = 16'd67;
   localparam logic [15:0] PORT_DHCP_CLIENT = 16'd68;

   // header offsets
   localparam logic [3:0] IHL_MASK       = 4'hF;
   localparam int MIN_FRAME_BYTES        = 14;
   localparam int IPV4_HEADER_BYTES      = 20;
   localparam int IPV4_PROTO_OFFSET      = 9;
   localparam int IPV4_ADDR_OFFSET       = 12;
   localparam int IPV6_NEXT_OFFSET       = 6;
   localparam int IPV6_HEADER_BYTES      = 40;
   localparam int IPV6_NEED_BYTES        = 7;
   localparam int ETHERTYPE_HI_POS       = 12;
   localparam int ETHERTYPE_LO_POS       = 13;

   // class codes
   localparam logic [3:0] CLASS_UNKNOWN_L2 = 4'd0;
   localparam logic [3:0] CLASS_ARP        = 4'd1;
   localparam logic [3:0] CLASS_TCP        = 4'd2;
   localparam logic [3:0] CLASS_FTP        = 4'd3;
   localparam logic [3:0] CLASS_SSH        = 4'd4;
   localparam logic [3:0] CLASS_TELNET     = 4'd5;
   localparam logic [3:0] CLASS_HTTP       = 4'd6;
   localparam logic [3:0] CLASS_HTTPS      = 4'd7;
   localparam logic [3:0] CLASS_UDP        = 4'd8;
   localparam logic [3:0] CLASS_DNS        = 4'd9;
   localparam logic [3:0] CLASS_DHCP       = 4'd10;
   localparam logic [3:0] CLASS_ICMPV4     = 4'd11;
   localparam logic [3:0] CLASS_ICMPV6     = 4'd12;
   localparam logic [3:0] CLASS_OTHER_IP   = 4'd13;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] packet_id;
      logic [3:0]  class_code;
      logic [15:0] ether_type;
      logic [7:0]  ip_protocol;
      logic [15:0] source_port;
      logic [15:0] destination_port;
      logic [7:0]  icmp_kind;
      logic [31:0] source_ipv4;
      logic [31:0] destination_ipv4;
      logic [15:0] captured_length;
      logic        truncated;
   } rsp_type;

endpackage

// ----- hw/rtl/frame_header_classifier.sv -----
// ----------------------------------------------------------------------------
// frame_header_classifier
// per-byte capture of ethernet / ipv4 / ipv6 / transport header fields with
// one classification record per frame
// ----------------------------------------------------------------------------
// output: the record is in the result register in the cycle after the last byte
// of a frame is transferred
// throughput: one byte per cycle, set by the single-pass capture and classify
// logic feeding the result register; the input stalls only while a record waits
// reset (synchronous): header offset 14, packet id 1, per-frame state cleared
// ----------------------------------------------------------------------------
module frame_header_classifier #(
   parameter int POSITION_BITS = fhc_pkg::POSITION_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // byte input channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  fhc_pkg::req_type                req_data,
   // record output channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output fhc_pkg::rsp_type                rsp_data,
   // configuration
   input  logic                            csr_wr_en,
   input  logic [fhc_pkg::LINK_BITS-1:0]   csr_wr_data
);

   localparam int EW = fhc_pkg::EXT_BITS;
   localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

   // configuration register
   logic [fhc_pkg::LINK_BITS-1:0] link_len_ff;

   // per-frame capture state
   logic [POSITION_BITS-1:0] pos_ff,     pos_in;
   logic [31:0]              frame_cnt_ff;
   logic [15:0]              type_ff,    type_in;
   logic [7:0]               toff_ff,    toff_in;
   logic [7:0]               proto_ff,   proto_in;
   logic [7:0]               v6_next_ff, v6_next_in;
   logic [3:0][7:0]          port_ff,    port_in;
   logic [3:0][7:0]          v6_win_ff,  v6_win_in;
   logic [7:0][7:0]          addr_ff,    addr_in;

   // output register
   logic                     rsp_valid_ff;
   fhc_pkg::rsp_type         rsp_data_ff, rsp_data_in;

   logic                     req_xfer;
   logic                     frame_end;

   // offset arithmetic in EW bits, with the current transport offset in 8 bits
   logic [EW-1:0] p_w, link_w, t6_w, toff_w;
   logic [EW-1:0] addr_rel, port_rel, v6_rel;
   logic [EW-1:0] need_w, tstart_w;
   logic [EW-1:0] len_w;
   logic [7:0]    toff_cur;

   // classification
   logic          is_ip;
   logic [7:0]    proto_sel;
   logic [31:0]   win_sel;
   logic [15:0]   sp, dp;

   // the input is held back only while a finished record is waiting
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_xfer  = req_valid & ~req_stall;
   assign frame_end = req_xfer & req_data.last_byte;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ------------------------------------------------------------------------
   // field capture for the byte being transferred
   // ------------------------------------------------------------------------
   always_comb begin
      p_w    = {{(EW-POSITION_BITS){1'b0}}, pos_ff};
      link_w = {{(EW-fhc_pkg::LINK_BITS){1'b0}}, link_len_ff};
      t6_w   = link_w + EW'(fhc_pkg::IPV6_HEADER_BYTES);

      type_in    = type_ff;
      proto_in   = proto_ff;
      v6_next_in = v6_next_ff;
      port_in    = port_ff;
      v6_win_in  = v6_win_ff;
      addr_in    = addr_ff;

      // ethertype, big-endian
      if (p_w == EW'(fhc_pkg::ETHERTYPE_HI_POS)) begin
         type_in[15:8] = req_data.data_byte;
      end
      if (p_w == EW'(fhc_pkg::ETHERTYPE_LO_POS)) begin
         type_in[7:0] = req_data.data_byte;
      end

      // ipv4 transport start from ihl; seen by the port window in the same byte
      if (p_w == link_w) begin
         toff_cur = 8'(link_len_ff) + {2'b00, req_data.data_byte[3:0] & fhc_pkg::IHL_MASK, 2'b00};
      end else begin
         toff_cur = toff_ff;
      end
      toff_w = {{(EW-8){1'b0}}, toff_cur};

      if (p_w == link_w + EW'(fhc_pkg::IPV4_PROTO_OFFSET)) begin
         proto_in = req_data.data_byte;
      end
      if (p_w == link_w + EW'(fhc_pkg::IPV6_NEXT_OFFSET)) begin
         v6_next_in = req_data.data_byte;
      end

      // source then destination ipv4 address
      addr_rel = p_w - (link_w + EW'(fhc_pkg::IPV4_ADDR_OFFSET));
      if (p_w >= link_w + EW'(fhc_pkg::IPV4_ADDR_OFFSET) && addr_rel < EW'(8)) begin
         addr_in[3'd7 - addr_rel[2:0]] = req_data.data_byte;
      end

      // first four ipv4 transport bytes
      port_rel = p_w - toff_w;
      if (p_w >= toff_w && port_rel < EW'(4)) begin
         port_in[2'd3 - port_rel[1:0]] = req_data.data_byte;
      end

      // first four ipv6 transport bytes
      v6_rel = p_w - t6_w;
      if (p_w >= t6_w && v6_rel < EW'(4)) begin
         v6_win_in[2'd3 - v6_rel[1:0]] = req_data.data_byte;
      end

      toff_in = toff_cur;
      pos_in  = (pos_ff < POS_MAX) ? pos_ff + 1'b1 : POS_MAX;
   end

   // ------------------------------------------------------------------------
   // classification on the updated fields
   // ------------------------------------------------------------------------
   always_comb begin
      rsp_data_in = '0;
      is_ip       = 1'b0;
      proto_sel   = '0;
      win_sel     = '0;
      tstart_w    = '0;
      need_w      = EW'(fhc_pkg::MIN_FRAME_BYTES);

      // captured length saturates at 16 bits
      len_w = p_w + EW'(1);
      if (len_w > EW'(16'hFFFF)) begin
         len_w = EW'(16'hFFFF);
      end

      rsp_data_in.packet_id       = frame_cnt_ff;
      rsp_data_in.ether_type      = type_in;
      rsp_data_in.captured_length = len_w[15:0];
      rsp_data_in.class_code      = fhc_pkg::CLASS_UNKNOWN_L2;

      if (type_in == fhc_pkg::ETHERTYPE_ARP) begin
         rsp_data_in.class_code = fhc_pkg::CLASS_ARP;
      end else if (type_in == fhc_pkg::ETHERTYPE_IPV4) begin
         is_ip     = 1'b1;
         proto_sel = proto_in;
         win_sel   = port_in;
         tstart_w  = toff_w;
         rsp_data_in.source_ipv4      = addr_in[7:4];
         rsp_data_in.destination_ipv4 = addr_in[3:0];
         if (need_w < link_w + EW'(fhc_pkg::IPV4_HEADER_BYTES)) begin
            need_w = link_w + EW'(fhc_pkg::IPV4_HEADER_BYTES);
         end
      end else if (type_in == fhc_pkg::ETHERTYPE_IPV6) begin
         is_ip     = 1'b1;
         proto_sel = v6_next_in;
         win_sel   = v6_win_in;
         tstart_w  = t6_w;
         if (need_w < link_w + EW'(fhc_pkg::IPV6_NEED_BYTES)) begin
            need_w = link_w + EW'(fhc_pkg::IPV6_NEED_BYTES);
         end
      end

      sp = win_sel[31:16];
      dp = win_sel[15:0];

      if (is_ip) begin
         rsp_data_in.ip_protocol = proto_sel;
         if (proto_sel == fhc_pkg::PROTO_TCP || proto_sel == fhc_pkg::PROTO_UDP) begin
            rsp_data_in.source_port      = sp;
            rsp_data_in.destination_port = dp;
            if (need_w < tstart_w + EW'(4)) begin
               need_w = tstart_w + EW'(4);
            end
            if (proto_sel == fhc_pkg::PROTO_TCP) begin
               if (sp == fhc_pkg::PORT_FTP || dp == fhc_pkg::PORT_FTP) begin
                  rsp_data_in.class_code = fhc_pkg::CLASS_FTP;
               end else if (sp == fhc_pkg::PORT_SSH || dp == fhc_pkg::PORT_SSH) begin
                  rsp_data_in.class_code = fhc_pkg::CLASS_SSH;
               end else if (sp == fhc_pkg::PORT_TELNET || dp == fhc_pkg::PORT_TELNET) begin
                  rsp_data_in.class_code = fhc_pkg::CLASS_TELNET;
               end else if (sp == fhc_pkg::PORT_HTTP || dp == fhc_pkg::PORT_HTTP) begin
                  rsp_data_in.class_code = fhc_pkg::CLASS_HTTP;
               end else if (sp == fhc_pkg::PORT_HTTPS || dp == fhc_pkg::PORT_HTTPS) begin
                  rsp_data_in.class_code = fhc_pkg::CLASS_HTTPS;
               end else begin
                  rsp_data_in.class_code = fhc_pkg::CLASS_TCP;
               end
            end else begin
               if (sp == fhc_pkg::PORT_DNS || dp == fhc_pkg::PORT_DNS) begin
                  rsp_data_in.class_code = fhc_pkg::CLASS_DNS;
               end else if (sp == fhc_pkg::PORT_DHCP_SERVER || dp == fhc_pkg::PORT_DHCP_SERVER
                         || sp == fhc_pkg::PORT_DHCP_CLIENT
                         || dp == fhc_pkg::PORT_DHCP_CLIENT) begin
                  rsp_data_in.class_code = fhc_pkg::CLASS_DHCP;
               end else begin
                  rsp_data_in.class_code = fhc_pkg::CLASS_UDP;
               end
            end
         end else if (proto_sel == fhc_pkg::PROTO_ICMPV4
                   || proto_sel == fhc_pkg::PROTO_ICMPV6) begin
            rsp_data_in.icmp_kind = win_sel[31:24];
            if (need_w < tstart_w + EW'(1)) begin
               need_w = tstart_w + EW'(1);
            end
            rsp_data_in.class_code = (proto_sel == fhc_pkg::PROTO_ICMPV4)
                                   ? fhc_pkg::CLASS_ICMPV4 : fhc_pkg::CLASS_ICMPV6;
         end else begin
            rsp_data_in.class_code = fhc_pkg::CLASS_OTHER_IP;
         end
      end

      // frame shorter than the last field the class relies on
      rsp_data_in.truncated = (len_w < need_w);
   end

   // ------------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         link_len_ff <= fhc_pkg::LINK_HEADER_RESET;
      end else if (csr_wr_en) begin
         link_len_ff <= csr_wr_data;
      end
   end

   // capture state; a last byte clears it for the next frame
   always_ff @(posedge clock) begin
      if (reset || frame_end) begin
         pos_ff     <= '0;
         type_ff    <= '0;
         toff_ff    <= '0;
         proto_ff   <= '0;
         v6_next_ff <= '0;
         port_ff    <= '0;
         v6_win_ff  <= '0;
         addr_ff    <= '0;
      end else if (req_xfer) begin
         pos_ff     <= pos_in;
         type_ff    <= type_in;
         toff_ff    <= toff_in;
         proto_ff   <= proto_in;
         v6_next_ff <= v6_next_in;
         port_ff    <= port_in;
         v6_win_ff  <= v6_win_in;
         addr_ff    <= addr_in;
      end
   end

   // running id, wraps at 32 bits
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_cnt_ff <= 32'd1;
      end else if (frame_end) begin
         frame_cnt_ff <= frame_cnt_ff + 32'd1;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (frame_end) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_end) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   // a last-byte transfer always leaves a record behind
   a_frame_gives_record: assert property (@(posedge clock) disable iff (reset)
      frame_end |=> rsp_valid_ff)
      else $error("no record after last byte");

   // per-frame position restarts after a frame ends
   a_frame_clears_pos: assert property (@(posedge clock) disable iff (reset)
      frame_end |=> (pos_ff == '0))
      else $error("byte position not cleared at frame end");

   // id advances by exactly one per frame
   a_id_step: assert property (@(posedge clock) disable iff (reset)
      frame_end |=> (frame_cnt_ff == $past(frame_cnt_ff) + 32'd1))
      else $error("packet id did not advance by one");

   // a taken record with no new frame end leaves the output empty
   a_record_drains: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_stall && !frame_end) |=> !rsp_valid_ff)
      else $error("record repeated after transfer");

endmodule
